// ===== rtl/bal_pkg.sv =====
package bal_pkg;

	localparam int MAX_ORDER  = 10;
	localparam int POOL_UNITS = 1 << MAX_ORDER;
	localparam int OFF_W      = 10;
	localparam int ORD_W      = 4;
	localparam int SIZE_W     = 11;
	localparam int CNT_W      = MAX_ORDER + 1;
	localparam int WORD_W     = 32;
	localparam int BIT_W      = 5;
	localparam int FM_WORDS   = 68;
	localparam int FM_AW      = 7;
	localparam int CLR_W      = 10;

	localparam logic [ORD_W-1:0] NO_BLOCK = 4'd15;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_BAD   = 2'd2;

	// first word of each level in the packed free map
	function automatic logic [FM_AW-1:0] fm_base(input logic [ORD_W-1:0] lvl);
		logic [FM_AW-1:0] b;
		case (lvl)
			4'd0:    b = 7'd0;
			4'd1:    b = 7'd32;
			4'd2:    b = 7'd48;
			4'd3:    b = 7'd56;
			4'd4:    b = 7'd60;
			4'd5:    b = 7'd62;
			4'd6:    b = 7'd63;
			4'd7:    b = 7'd64;
			4'd8:    b = 7'd65;
			4'd9:    b = 7'd66;
			4'd10:   b = 7'd67;
			default: b = 7'd0;
		endcase
		return b;
	endfunction

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CFG,
		OP_CLEAR,
		OP_LOAD,
		OP_SCAN_START,
		OP_SCAN_NEXT,
		OP_TAKE,
		OP_SPLIT_RD,
		OP_SET_WR,
		OP_REC,
		OP_FREE_CLR,
		OP_BUD_RD,
		OP_BUD_TAKE,
		OP_HOME_RD,
		OP_EMIT
	} bal_op_t;

	typedef struct packed {
		bal_op_t    op;
		logic [1:0] code;
	} bal_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic alloc_bad;
		logic alloc_none;
		logic free_oob;
		logic bo_bad;
		logic word_hit;
		logic split_more;
		logic merge_more;
		logic bud_free;
	} bal_stat_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_SPLIT,
		S_SPLIT_WR,
		S_MERGE,
		S_BUD_CHK,
		S_HOME_WR,
		S_EMIT_OK,
		S_EMIT_NOFIT,
		S_EMIT_BAD
	} bal_state_t;

endpackage

// ===== rtl/bal_req_if.sv =====
interface bal_req_if;
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [bal_pkg::SIZE_W-1:0] size;
	logic [bal_pkg::OFF_W-1:0]  offset;

	modport source (output valid, action, size, offset, input ready);
	modport sink (input valid, action, size, offset, output ready);
endinterface

// ===== rtl/bal_rsp_if.sv =====
interface bal_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [bal_pkg::OFF_W-1:0]  offset_res;
	logic [bal_pkg::ORD_W-1:0]  order;

	modport source (output valid, status, offset_res, order, input ready);
	modport sink (input valid, status, offset_res, order, output ready);
endinterface

// ===== rtl/bal_cfg_if.sv =====
interface bal_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [bal_pkg::ORD_W-1:0] pool_order;

	modport source (output valid, pool_order, input ready);
	modport sink (input valid, pool_order, output ready);
endinterface

// ===== rtl/bal_ctrl.sv =====
module bal_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  bal_pkg::bal_stat_t stat,
	output bal_pkg::bal_cmd_t  cmd
);
	import bal_pkg::*;

	bal_state_t state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (stat.clr_last) state_d = S_IDLE;
			S_IDLE: begin
				if (cfg_valid) state_d = S_CLEAR;
				else if (req_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.is_free) begin
					if (stat.free_oob || stat.bo_bad) state_d = S_EMIT_BAD;
					else state_d = S_MERGE;
				end else if (stat.alloc_bad) begin
					state_d = S_EMIT_BAD;
				end else if (stat.alloc_none) begin
					state_d = S_EMIT_NOFIT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: if (stat.word_hit) state_d = S_SPLIT;
			S_SPLIT: state_d = stat.split_more ? S_SPLIT_WR : S_EMIT_OK;
			S_SPLIT_WR: state_d = S_SPLIT;
			S_MERGE: state_d = stat.merge_more ? S_BUD_CHK : S_HOME_WR;
			S_BUD_CHK: state_d = stat.bud_free ? S_MERGE : S_HOME_WR;
			S_HOME_WR: state_d = S_EMIT_OK;
			S_EMIT_OK, S_EMIT_NOFIT, S_EMIT_BAD: if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.code  = STAT_OK;
		req_ready = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.op = OP_CLEAR;
			S_IDLE: begin
				cfg_ready = 1'b1;
				req_ready = !cfg_valid;
				if (cfg_valid) cmd.op = OP_CFG;
				else if (req_valid) cmd.op = OP_LOAD;
			end
			S_DECIDE: begin
				if (stat.is_free) begin
					if (!(stat.free_oob || stat.bo_bad)) cmd.op = OP_FREE_CLR;
				end else if (!stat.alloc_bad && !stat.alloc_none) begin
					cmd.op = OP_SCAN_START;
				end
			end
			S_SCAN: cmd.op = stat.word_hit ? OP_TAKE : OP_SCAN_NEXT;
			S_SPLIT: cmd.op = stat.split_more ? OP_SPLIT_RD : OP_REC;
			S_SPLIT_WR: cmd.op = OP_SET_WR;
			S_MERGE: cmd.op = stat.merge_more ? OP_BUD_RD : OP_HOME_RD;
			S_BUD_CHK: cmd.op = stat.bud_free ? OP_BUD_TAKE : OP_HOME_RD;
			S_HOME_WR: cmd.op = OP_SET_WR;
			S_EMIT_OK: if (slot_free) cmd.op = OP_EMIT;
			S_EMIT_NOFIT: begin
				cmd.code = STAT_NOFIT;
				if (slot_free) cmd.op = OP_EMIT;
			end
			S_EMIT_BAD: begin
				cmd.code = STAT_BAD;
				if (slot_free) cmd.op = OP_EMIT;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/bal_dp.sv =====
module bal_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bal_pkg::bal_cmd_t           cmd,
	output bal_pkg::bal_stat_t          stat,
	input  logic                        in_action,
	input  logic [bal_pkg::SIZE_W-1:0]  in_size,
	input  logic [bal_pkg::OFF_W-1:0]   in_offset,
	input  logic [bal_pkg::ORD_W-1:0]   cfg_order,
	output logic [1:0]                  out_status,
	output logic [bal_pkg::OFF_W-1:0]   out_offset,
	output logic [bal_pkg::ORD_W-1:0]   out_order
);
	import bal_pkg::*;

	logic [WORD_W-1:0] fm_mem [FM_WORDS];
	logic [ORD_W-1:0]  bo_mem [POOL_UNITS];
	logic [WORD_W-1:0] fm_rd_q;
	logic [ORD_W-1:0]  bo_rd_q;

	logic [CNT_W-1:0]  cnt_q [MAX_ORDER+1];
	logic [ORD_W-1:0]  pool_q, k_q, lvl_q;
	logic [CLR_W-1:0]  clr_q;
	logic              action_q, none_q, bad_q, oob_q;
	logic [OFF_W-1:0]  pos_q;
	logic [BIT_W-1:0]  w_q, node_bit_q;
	logic [FM_AW-1:0]  node_addr_q;

	logic [ORD_W-1:0]  k_c, lvl_c, pool_c, node_lvl;
	logic              hit_c;
	logic [BIT_W-1:0]  low_bit;
	logic [OFF_W-1:0]  node_idx, shifted;
	logic [FM_AW-1:0]  node_addr, scan_addr;

	logic              fm_we, fm_re, bo_we;
	logic [FM_AW-1:0]  fm_waddr, fm_raddr;
	logic [WORD_W-1:0] fm_wdata;
	logic [OFF_W-1:0]  bo_waddr;
	logic [ORD_W-1:0]  bo_wdata;

	assign pool_c = (cfg_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : cfg_order;

	// size rounded up to a power of two
	always_comb begin
		k_c = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if ((12'd1 << i) < {1'b0, in_size}) k_c = ORD_W'(i + 1);
		end
	end

	// lowest level at or above k holding any free block
	always_comb begin
		lvl_c = '0;
		hit_c = 1'b0;
		for (int l = MAX_ORDER; l >= 0; l--) begin
			if (ORD_W'(l) >= k_c && ORD_W'(l) <= pool_q && cnt_q[l] != '0) begin
				lvl_c = ORD_W'(l);
				hit_c = 1'b1;
			end
		end
	end

	always_comb begin
		low_bit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (fm_rd_q[i]) low_bit = BIT_W'(i);
		end
	end

	assign node_lvl  = (cmd.op == OP_SPLIT_RD) ? lvl_q - 4'd1 : lvl_q;
	assign shifted   = pos_q >> node_lvl;
	always_comb begin
		case (cmd.op)
			OP_BUD_RD:   node_idx = shifted ^ 10'd1;
			OP_SPLIT_RD: node_idx = shifted | 10'd1;
			default:     node_idx = shifted;
		endcase
	end
	assign node_addr = fm_base(node_lvl) + FM_AW'(node_idx[OFF_W-1:BIT_W]);
	assign scan_addr = fm_base(lvl_q) + FM_AW'(w_q);

	always_comb begin
		fm_we    = 1'b0;
		fm_waddr = node_addr_q;
		fm_wdata = fm_rd_q;
		fm_re    = 1'b0;
		fm_raddr = node_addr;
		bo_we    = 1'b0;
		bo_waddr = pos_q;
		bo_wdata = NO_BLOCK;
		case (cmd.op)
			OP_CLEAR: begin
				fm_we    = clr_q < CLR_W'(FM_WORDS);
				fm_waddr = clr_q[FM_AW-1:0];
				fm_wdata = (clr_q[FM_AW-1:0] == fm_base(pool_q)) ? WORD_W'(1) : '0;
				bo_we    = 1'b1;
				bo_waddr = clr_q;
			end
			OP_SCAN_START: begin
				fm_re    = 1'b1;
				fm_raddr = fm_base(lvl_q);
			end
			OP_SCAN_NEXT: begin
				fm_re    = 1'b1;
				fm_raddr = scan_addr + 7'd1;
			end
			OP_TAKE: begin
				fm_we    = 1'b1;
				fm_waddr = scan_addr;
				fm_wdata = fm_rd_q & ~(WORD_W'(1) << low_bit);
			end
			OP_SPLIT_RD, OP_BUD_RD, OP_HOME_RD: fm_re = 1'b1;
			OP_SET_WR: begin
				fm_we    = 1'b1;
				fm_wdata = fm_rd_q | (WORD_W'(1) << node_bit_q);
			end
			OP_BUD_TAKE: begin
				fm_we    = 1'b1;
				fm_wdata = fm_rd_q & ~(WORD_W'(1) << node_bit_q);
			end
			OP_REC: begin
				bo_we    = 1'b1;
				bo_wdata = k_q;
			end
			OP_FREE_CLR: bo_we = 1'b1;
			default: fm_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fm_we) fm_mem[fm_waddr] <= fm_wdata;
		if (fm_re) fm_rd_q <= fm_mem[fm_raddr];
		if (bo_we) bo_mem[bo_waddr] <= bo_wdata;
		if (cmd.op == OP_LOAD) bo_rd_q <= bo_mem[in_offset];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= ORD_W'(MAX_ORDER);
			clr_q  <= '0;
			for (int l = 0; l <= MAX_ORDER; l++) begin
				cnt_q[l] <= (l == MAX_ORDER) ? CNT_W'(1) : '0;
			end
		end else begin
			case (cmd.op)
				OP_CFG: begin
					pool_q <= pool_c;
					clr_q  <= '0;
					for (int l = 0; l <= MAX_ORDER; l++) begin
						cnt_q[l] <= (ORD_W'(l) == pool_c) ? CNT_W'(1) : '0;
					end
				end
				OP_CLEAR: clr_q <= clr_q + 10'd1;
				OP_TAKE, OP_BUD_TAKE: cnt_q[lvl_q] <= cnt_q[lvl_q] - 11'd1;
				OP_SET_WR: cnt_q[lvl_q] <= cnt_q[lvl_q] + 11'd1;
				default: clr_q <= clr_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				action_q <= in_action;
				k_q      <= k_c;
				lvl_q    <= lvl_c;
				none_q   <= !hit_c;
				bad_q    <= in_size == '0;
				oob_q    <= {1'b0, in_offset} >= (11'd1 << pool_q);
				pos_q    <= in_offset;
			end
			OP_SCAN_START: w_q <= '0;
			OP_SCAN_NEXT: w_q <= w_q + 5'd1;
			OP_TAKE: pos_q <= OFF_W'({w_q, low_bit} << lvl_q);
			OP_SPLIT_RD, OP_BUD_RD, OP_HOME_RD: begin
				node_addr_q <= node_addr;
				node_bit_q  <= node_idx[BIT_W-1:0];
				lvl_q       <= node_lvl;
			end
			OP_BUD_TAKE: begin
				pos_q <= pos_q & ~(10'd1 << lvl_q);
				lvl_q <= lvl_q + 4'd1;
			end
			OP_FREE_CLR: lvl_q <= bo_rd_q;
			OP_EMIT: begin
				out_status <= cmd.code;
				out_offset <= (cmd.code == STAT_OK) ? pos_q : '0;
				out_order  <= (cmd.code == STAT_OK) ? lvl_q : '0;
			end
			default: w_q <= w_q;
		endcase
	end

	assign stat.clr_last   = clr_q == '1;
	assign stat.is_free    = action_q;
	assign stat.alloc_bad  = bad_q;
	assign stat.alloc_none = none_q;
	assign stat.free_oob   = oob_q;
	assign stat.bo_bad     = bo_rd_q == NO_BLOCK || bo_rd_q > pool_q;
	assign stat.word_hit   = fm_rd_q != '0;
	assign stat.split_more = lvl_q > k_q;
	assign stat.merge_more = lvl_q < pool_q;
	assign stat.bud_free   = fm_rd_q[node_bit_q];

endmodule

// ===== rtl/buddy_allocator.sv =====
// Binary buddy allocator over 2^pool_order minimum units (pool_order <= 10).
// req: one transfer per request. action 0 allocates size units (rounded up
//   to a power of two), action 1 frees the block starting at offset.
// rsp: one transfer per request with status (0 ok, 1 no fit, 2 bad request),
//   offset_res and order of the allocated or merged block.
// cfg: writes pool_order (clamped to 10) and reinitializes the whole pool.
// Requests are handled one at a time. Allocate scans the free-map words of
// the chosen level (1 to 32) and then splits down one level at a time; free
// merges up one level at a time. The single port free-map memory takes one
// level per read-modify-write.
// After reset and after every cfg transfer a clearing pass runs over the
// block-order memory and free map; req and cfg are not ready then.
// The result sits in an output register; a new request is taken while it
// waits. If rsp stalls, the next result waits in an emit state of the
// controller until the output register frees up.
module buddy_allocator (
	input logic        clk,
	input logic        arst_n,
	bal_req_if.sink    req,
	bal_rsp_if.source  rsp,
	bal_cfg_if.sink    cfg
);
	import bal_pkg::*;

	bal_cmd_t  cmd;
	bal_stat_t stat;

	bal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bal_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_action  (req.action),
		.in_size    (req.size),
		.in_offset  (req.offset),
		.cfg_order  (cfg.pool_order),
		.out_status (rsp.status),
		.out_offset (rsp.offset_res),
		.out_order  (rsp.order)
	);

endmodule
